@@ rtl/fsc_pkg.sv @@
// shared types, codes and defaults of the floor span coalescer
package fsc_pkg;

	localparam int ROWS_DEF    = 480;
	localparam int COLUMNS_DEF = 640;

	localparam int OP_W   = 2;
	localparam int COL_W  = 10;
	localparam int ROW_W  = 9;
	localparam int CODE_W = 16;
	localparam int SECT_W = 15;

	localparam logic [OP_W-1:0] OP_OPEN  = 2'd0;
	localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
	localparam logic [OP_W-1:0] OP_FRAME = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
		logic [CODE_W-1:0] sector_code;
	} item_t;

	typedef struct packed {
		logic [ROW_W-1:0]  span_row;
		logic [COL_W-1:0]  span_first;
		logic [COL_W-1:0]  span_last;
		logic [SECT_W-1:0] span_sector;
		logic              is_ceiling;
	} span_t;

	typedef struct packed {
		logic              open_flag;
		logic [COL_W-1:0]  open_start;
		logic [COL_W-1:0]  closed_column;
		logic [CODE_W-1:0] closed_code;
	} row_data_t;

	typedef struct packed {
		row_data_t data;
		logic      pend;
	} row_state_t;

	typedef struct packed {
		logic             data_en;
		logic             pend_en;
		logic [ROW_W-1:0] addr;
		row_state_t       state;
	} wr_cmd_t;

endpackage

@@ rtl/fsc_row_store.sv @@
// per-row state memories with registered read and one-deep write forwarding
module fsc_row_store #(
	parameter int ROWS = fsc_pkg::ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [fsc_pkg::ROW_W-1:0]  rd_addr,
	input  fsc_pkg::wr_cmd_t           wr,
	output fsc_pkg::row_state_t        rd_state
);

	localparam int RW = $clog2(ROWS);

	fsc_pkg::row_data_t  data_mem [ROWS];
	logic                pend_mem [ROWS];

	fsc_pkg::row_data_t  data_q;
	logic                pend_q;
	fsc_pkg::row_state_t byp_q;
	logic                hit_data_q;
	logic                hit_pend_q;

	always_ff @(posedge clk) begin
		if (wr.data_en) begin
			data_mem[wr.addr[RW-1:0]] <= wr.state.data;
		end
		if (wr.pend_en) begin
			pend_mem[wr.addr[RW-1:0]] <= wr.state.pend;
		end
		if (rd_en) begin
			data_q <= data_mem[rd_addr[RW-1:0]];
			pend_q <= pend_mem[rd_addr[RW-1:0]];
			byp_q  <= wr.state;
		end
	end

	// write landing on the same edge as the read: take the written value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_data_q <= 1'b0;
			hit_pend_q <= 1'b0;
		end else if (rd_en) begin
			hit_data_q <= wr.data_en && (wr.addr == rd_addr);
			hit_pend_q <= wr.pend_en && (wr.addr == rd_addr);
		end
	end

	assign rd_state.data = hit_data_q ? byp_q.data : data_q;
	assign rd_state.pend = hit_pend_q ? byp_q.pend : pend_q;

endmodule

@@ rtl/fsc_span_unit.sv @@
// next row state and span closeout for one post event
module fsc_span_unit #(
	parameter int ROWS    = fsc_pkg::ROWS_DEF,
	parameter int COLUMNS = fsc_pkg::COLUMNS_DEF
) (
	input  fsc_pkg::item_t      item,
	input  fsc_pkg::row_state_t cur,
	output fsc_pkg::row_state_t nxt,
	output logic                wen,
	output logic                emit,
	output fsc_pkg::span_t      span
);

	localparam logic [fsc_pkg::COL_W-1:0] LAST_COL = fsc_pkg::COL_W'(COLUMNS - 1);
	localparam logic [fsc_pkg::COL_W:0]   COL_LIM  = (fsc_pkg::COL_W + 1)'(COLUMNS);
	localparam logic [fsc_pkg::ROW_W:0]   ROW_LIM  = (fsc_pkg::ROW_W + 1)'(ROWS);

	logic                      in_range;
	logic                      reopen;
	logic                      do_close;
	logic                      span_ok;
	logic [fsc_pkg::COL_W-1:0] first;
	logic [fsc_pkg::COL_W:0]   next_col;

	assign in_range = {1'b0, item.row} < ROW_LIM;
	assign next_col = {1'b0, cur.data.closed_column} + 1'b1;
	assign reopen   = cur.pend && (next_col == {1'b0, item.column})
		&& (cur.data.closed_code == item.sector_code);
	assign first    = (cur.data.open_start > LAST_COL) ? LAST_COL : cur.data.open_start;
	assign span_ok  = ({1'b0, cur.data.closed_column} < COL_LIM)
		&& (first <= cur.data.closed_column);

	always_comb begin
		do_close = 1'b0;
		nxt      = cur;
		case (item.operation)
			fsc_pkg::OP_OPEN: begin
				if (reopen) begin
					nxt.pend = 1'b0;
				end else begin
					do_close            = cur.data.open_flag;
					nxt.data.open_start = item.column;
					nxt.data.open_flag  = 1'b1;
					if (cur.data.open_flag && cur.pend) begin
						nxt.pend = 1'b0;
					end
				end
			end
			fsc_pkg::OP_CLOSE: begin
				do_close               = 1'b1;
				nxt.data.closed_column = item.column;
				nxt.data.closed_code   = item.sector_code;
				nxt.pend               = 1'b1;
				if (cur.pend) begin
					nxt.data.open_flag = 1'b0;
				end
			end
			fsc_pkg::OP_FLUSH: begin
				do_close = cur.data.open_flag;
				if (cur.data.open_flag && cur.pend) begin
					nxt.pend           = 1'b0;
					nxt.data.open_flag = 1'b0;
				end
			end
			default: begin
				do_close = 1'b0;
			end
		endcase
	end

	assign wen  = in_range && (item.operation != fsc_pkg::OP_FRAME);
	assign emit = wen && do_close && cur.pend && span_ok;

	assign span.span_row    = item.row;
	assign span.span_first  = first;
	assign span.span_last   = cur.data.closed_column;
	assign span.span_sector = cur.data.closed_code[fsc_pkg::SECT_W-1:0];
	assign span.is_ceiling  = cur.data.closed_code[fsc_pkg::CODE_W-1];

endmodule

@@ rtl/floor_span_coalescer.sv @@
// top level of the floor span coalescer: handshake, pipeline and clearing sweeps
//
// Post events arrive one per transaction on the item channel, each naming a row, a
// column, a sector code and an operation (open, close, flush, frame start), and at
// most one finished span per event leaves on the span channel. Open, close and
// flush events are taken one per clock while the span side does not stall: the
// row state is read from memory on the accepting edge, updated as the event
// leaves the stage with forwarding from the event just ahead, and the span lands
// in an output register that is held while the span side stalls. A frame start
// event clears the pending close of every row by a sweep of the pending-bit memory,
// with the item side stalled meanwhile; after reset a sweep clears all row state
// before the first event is taken. Rows at or beyond ROWS are accepted and ignored.
module floor_span_coalescer #(
	parameter int ROWS    = fsc_pkg::ROWS_DEF,
	parameter int COLUMNS = fsc_pkg::COLUMNS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  fsc_pkg::item_t item,
	output logic           span_valid,
	input  logic           span_stall,
	output fsc_pkg::span_t span
);

	localparam int RW = $clog2(ROWS);
	localparam logic [fsc_pkg::ROW_W:0] ROW_LIM = (fsc_pkg::ROW_W + 1)'(ROWS);

	// sweep sequencer
	typedef enum logic [2:0] {
		ST_INIT  = 3'b001,
		ST_RUN   = 3'b010,
		ST_FRAME = 3'b100
	} state_t;

	state_t              state_q;
	logic [RW-1:0]       sweep_cnt_q;
	logic                sweep_last;

	// event stage and result register
	logic                item_accept;
	logic                item_valid_s1;
	fsc_pkg::item_t      item_s1;
	logic                advance;
	logic                span_valid_q;
	fsc_pkg::span_t      span_q;

	// row state traffic
	fsc_pkg::row_state_t cur_state;
	fsc_pkg::row_state_t nxt_state;
	fsc_pkg::wr_cmd_t    wr;
	logic                rd_en;
	logic                unit_wen;
	logic                unit_emit;
	fsc_pkg::span_t      unit_span;

	// the event stage may move on when the result register is empty or being taken
	assign advance     = !span_valid_q || !span_stall;
	assign item_stall  = (state_q != ST_RUN) || (item_valid_s1 && !advance);
	assign item_accept = item_valid && !item_stall;
	assign rd_en       = item_accept && ({1'b0, item.row} < ROW_LIM)
		&& (item.operation != fsc_pkg::OP_FRAME);
	assign sweep_last  = sweep_cnt_q == RW'(ROWS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_INIT, ST_FRAME: begin
					sweep_cnt_q <= sweep_last ? '0 : sweep_cnt_q + 1'b1;
					if (sweep_last) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// frame start: the event itself writes nothing, so the sweep
					// owns the write port from the next cycle on
					if (item_accept && (item.operation == fsc_pkg::OP_FRAME)) begin
						state_q <= ST_FRAME;
					end
				end
				default: begin
					state_q     <= ST_INIT;
					sweep_cnt_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_accept) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			item_s1 <= item;
		end
	end

	// write port: clearing sweeps, otherwise the event leaving the stage
	always_comb begin
		wr = '0;
		case (state_q)
			ST_INIT: begin
				wr.data_en = 1'b1;
				wr.pend_en = 1'b1;
				wr.addr    = fsc_pkg::ROW_W'(sweep_cnt_q);
			end
			ST_FRAME: begin
				wr.pend_en = 1'b1;
				wr.addr    = fsc_pkg::ROW_W'(sweep_cnt_q);
			end
			default: begin
				wr.data_en = item_valid_s1 && advance && unit_wen;
				wr.pend_en = item_valid_s1 && advance && unit_wen;
				wr.addr    = item_s1.row;
				wr.state   = nxt_state;
			end
		endcase
	end

	fsc_row_store #(
		.ROWS (ROWS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (item.row),
		.wr       (wr),
		.rd_state (cur_state)
	);

	fsc_span_unit #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_unit (
		.item (item_s1),
		.cur  (cur_state),
		.nxt  (nxt_state),
		.wen  (unit_wen),
		.emit (unit_emit),
		.span (unit_span)
	);

	// result register, held while the span side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (advance) begin
			span_valid_q <= item_valid_s1 && unit_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid_s1 && unit_emit) begin
			span_q <= unit_span;
		end
	end

	assign span_valid = span_valid_q;
	assign span       = span_q;

	// a held event must not touch the row memories
	a_hold_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && item_valid_s1 && !advance) |-> !wr.data_en && !wr.pend_en)
		else $error("row state written while the event stage is held");

	// a frame start shuts the item side for the sweep
	a_frame_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(item_accept && item.operation == fsc_pkg::OP_FRAME) |=> item_stall)
		else $error("item taken straight after a frame start");

	// an offered span stays until it is taken
	a_span_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(span_valid && span_stall) |=> span_valid && $stable(span))
		else $error("stalled span lost or changed");

	// the sweep counter rests at zero outside the sweeps
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (sweep_cnt_q == '0))
		else $error("sweep counter running outside a sweep");

endmodule
